// ===== rtl/video_dot_timing_scroll_unit_assert.svh =====
// ----------------------------------------------------------------------------
// video_dot_timing_scroll_unit_assert.svh
// Assertion macros shared by the dot timing and scroll unit.
// ----------------------------------------------------------------------------
`ifndef VIDEO_DOT_TIMING_SCROLL_UNIT_ASSERT_SVH
`define VIDEO_DOT_TIMING_SCROLL_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define VDTS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vdts: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define VDTS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vdts: next-cycle check failed");

`endif

// ===== rtl/vdts_pkg.sv =====
// ----------------------------------------------------------------------------
// vdts_pkg
// Types and constants of the video dot timing and scroll unit.
// ----------------------------------------------------------------------------
package vdts_pkg;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_LOAD   = 2'd1;
	localparam logic [1:0] REQ_STATUS = 2'd2;
	localparam logic [1:0] REQ_RELOAD = 2'd3;

	localparam logic CFG_CLOCK_DIVIDE = 1'b0;
	localparam logic CFG_IRQ_RELOAD   = 1'b1;

	localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
	localparam logic [8:0] VBLANK_LINE       = 9'd240;
	localparam logic [8:0] PRERENDER_LINE    = 9'd261;
	localparam logic [8:0] IRQ_DOT           = 9'd255;

	localparam logic [13:0] NT_BASE = 14'h2000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [14:0] new_address;
		logic [14:0] temp_address;
		logic [2:0]  fine_x;
		logic        rendering_on;
		logic        nmi_enable;
		logic        irq_enabled;
		logic        cpu_irq_masked;
	} in_item_t;

	typedef struct packed {
		logic        dot_step;
		logic [8:0]  dot_x;
		logic [8:0]  scanline;
		logic [14:0] scroll_address;
		logic        fetch_valid;
		logic [13:0] fetch_address;
		logic        vblank_flag;
		logic        nmi_pulse;
		logic        irq_pulse;
	} out_item_t;

	// dot position under work and whether this item advances it
	typedef struct packed {
		logic       step;
		logic [8:0] x;
		logic [8:0] y;
	} dot_t;

endpackage

// ===== rtl/vdts_timing.sv =====
// ----------------------------------------------------------------------------
// vdts_timing
// Master clock divider and the 341 x 262 dot and scanline counters.
// ----------------------------------------------------------------------------
module vdts_timing (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              tick,
	input  logic [2:0]        clock_divide,
	output vdts_pkg::dot_t    dot
);
	import vdts_pkg::*;

	localparam logic [8:0] LAST_DOT  = 9'd340;
	localparam logic [8:0] LAST_LINE = 9'd261;

	logic [2:0] div_q;
	logic [2:0] div_inc;
	logic [8:0] x_q;
	logic [8:0] y_q;
	logic       step;

	// the count wraps in three bits; reaching or passing the setting makes a dot
	assign div_inc = div_q + 3'd1;
	assign step    = tick && (div_inc >= clock_divide);

	assign dot.step = step;
	assign dot.x    = x_q;
	assign dot.y    = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
			x_q   <= '0;
			y_q   <= '0;
		end else if (accept && tick) begin
			div_q <= step ? 3'd0 : div_inc;
			if (step) begin
				if (x_q == LAST_DOT) begin
					x_q <= '0;
					y_q <= (y_q == LAST_LINE) ? 9'd0 : y_q + 9'd1;
				end else begin
					x_q <= x_q + 9'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/vdts_scroll.sv =====
// ----------------------------------------------------------------------------
// vdts_scroll
// Scroll address register with coarse-X, fine-Y and copy rules.
// ----------------------------------------------------------------------------
module vdts_scroll (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              load,
	input  logic [14:0]       new_address,
	input  logic [14:0]       temp_address,
	input  logic [2:0]        fine_x,
	input  logic              rendering_on,
	input  vdts_pkg::dot_t    dot,
	output logic [14:0]       scroll_next,
	output logic              fetch_valid
);
	import vdts_pkg::*;

	localparam logic [14:0] VCOPY_MASK    = 15'h7BE0;
	localparam logic [14:0] HCOPY_MASK    = 15'h041F;
	localparam logic [14:0] FINE_Y_MASK   = 15'h7000;
	localparam logic [14:0] COARSE_Y_MASK = 15'h03E0;
	localparam logic [14:0] COARSE_Y_LAST = 15'h03A0;
	localparam logic [14:0] NT_X_BIT      = 15'h0400;
	localparam logic [14:0] NT_Y_BIT      = 15'h0800;
	localparam logic [14:0] FINE_Y_ONE    = 15'h1000;
	localparam logic [14:0] COARSE_Y_ONE  = 15'h0020;
	localparam logic [14:0] COARSE_X_MASK = 15'h001F;
	localparam logic [8:0]  VCOPY_FIRST   = 9'd279;
	localparam logic [8:0]  VCOPY_LAST    = 9'd303;
	localparam logic [8:0]  HCOPY_DOT     = 9'd256;

	logic [14:0] scroll_q;
	logic [14:0] v_copy;
	logic [14:0] v_cx;
	logic [14:0] v_fy;
	logic [14:0] v_hc;
	logic [14:0] fy_clr;
	logic        active;
	logic        render_line;
	logic        cx_due;

	function automatic logic [14:0] step_coarse_x(input logic [14:0] v);
		if ((v & COARSE_X_MASK) == COARSE_X_MASK)
			return (v ^ NT_X_BIT) & ~COARSE_X_MASK;
		return v + 15'd1;
	endfunction

	assign active      = dot.step && rendering_on;
	assign render_line = (dot.y <= LAST_VISIBLE_LINE) || (dot.y == PRERENDER_LINE);
	assign cx_due      = active && render_line && (dot.x < HCOPY_DOT)
		&& ((dot.x[2:0] + fine_x) == 3'd7);

	always_comb begin
		v_copy = scroll_q;
		if (active && dot.y == PRERENDER_LINE && dot.x >= VCOPY_FIRST && dot.x <= VCOPY_LAST)
			v_copy = (scroll_q & ~VCOPY_MASK) | (temp_address & VCOPY_MASK);

		v_cx = cx_due ? step_coarse_x(v_copy) : v_copy;

		// fine-Y rolls into coarse-Y, which wraps at row 29 into the other nametable
		fy_clr = v_cx & ~FINE_Y_MASK;
		if ((v_cx & FINE_Y_MASK) != FINE_Y_MASK)
			v_fy = v_cx + FINE_Y_ONE;
		else if ((fy_clr & COARSE_Y_MASK) == COARSE_Y_LAST)
			v_fy = (fy_clr ^ NT_Y_BIT) & ~COARSE_Y_MASK;
		else if ((fy_clr & COARSE_Y_MASK) == COARSE_Y_MASK)
			v_fy = fy_clr & ~COARSE_Y_MASK;
		else
			v_fy = fy_clr + COARSE_Y_ONE;
		if (!(active && render_line && dot.x == IRQ_DOT))
			v_fy = v_cx;

		v_hc = v_fy;
		if (active && render_line && dot.x == HCOPY_DOT)
			v_hc = (v_fy & ~HCOPY_MASK) | (temp_address & HCOPY_MASK);

		scroll_next = load ? new_address : v_hc;
	end

	assign fetch_valid = cx_due || (active && render_line && dot.x == HCOPY_DOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q <= '0;
		end else if (accept) begin
			scroll_q <= scroll_next;
		end
	end

endmodule

// ===== rtl/vdts_irq.sv =====
// ----------------------------------------------------------------------------
// vdts_irq
// Scanline IRQ counter with reload latch, clocked at dot 255.
// ----------------------------------------------------------------------------
module vdts_irq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              reload_req,
	input  logic [7:0]        reload_value,
	input  logic              rendering_on,
	input  logic              irq_enabled,
	input  logic              cpu_irq_masked,
	input  vdts_pkg::dot_t    dot,
	output logic              irq_pulse
);
	import vdts_pkg::*;

	logic [7:0] count_q;
	logic       latch_q;
	logic [7:0] count_next;
	logic       clocked;

	assign clocked = dot.step && rendering_on && dot.x == IRQ_DOT
		&& dot.y <= LAST_VISIBLE_LINE;
	assign count_next = (count_q == 8'd0 || latch_q) ? reload_value : count_q - 8'd1;
	assign irq_pulse  = clocked && irq_enabled && !cpu_irq_masked && count_next == 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			latch_q <= 1'b0;
		end else if (accept) begin
			if (reload_req)
				latch_q <= 1'b1;
			if (clocked) begin
				count_q <= count_next;
				latch_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/video_dot_timing_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// video_dot_timing_scroll_unit
// Dot timing, loopy scroll address and scanline IRQ counter.
// ----------------------------------------------------------------------------
// One item enters per clock while in_ready is high: each accepted item updates the dot
// counters, scroll address, IRQ counter and vblank flag in the cycle it is
// taken, and its result is captured in the result register. The
// result register is the only stage, so in_ready stays high while it is empty
// or being taken, and one result leaves per clock when out_ready is held high.
// Configuration writes land on the next clock edge.
module video_dot_timing_scroll_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  vdts_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vdts_pkg::out_item_t   out_data
);
	import vdts_pkg::*;

	logic [2:0]  clock_divide_q;
	logic [7:0]  irq_reload_q;
	logic        vblank_q;
	logic        vblank_next;
	logic        vblank_set;
	logic        accept;
	logic        out_valid_q;
	out_item_t   out_q;
	dot_t        dot;
	logic [14:0] scroll_next;
	logic        fetch_valid;
	logic        irq_pulse;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	vdts_timing u_timing (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.tick         (in_data.req_type == REQ_TICK),
		.clock_divide (clock_divide_q),
		.dot          (dot)
	);

	vdts_scroll u_scroll (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.load         (in_data.req_type == REQ_LOAD),
		.new_address  (in_data.new_address),
		.temp_address (in_data.temp_address),
		.fine_x       (in_data.fine_x),
		.rendering_on (in_data.rendering_on),
		.dot          (dot),
		.scroll_next  (scroll_next),
		.fetch_valid  (fetch_valid)
	);

	vdts_irq u_irq (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.reload_req     (in_data.req_type == REQ_RELOAD),
		.reload_value   (irq_reload_q),
		.rendering_on   (in_data.rendering_on),
		.irq_enabled    (in_data.irq_enabled),
		.cpu_irq_masked (in_data.cpu_irq_masked),
		.dot            (dot),
		.irq_pulse      (irq_pulse)
	);

	assign vblank_set  = dot.step && dot.y == VBLANK_LINE && dot.x == 9'd1;
	assign vblank_next = (in_data.req_type == REQ_STATUS) ? 1'b0 : (vblank_set || vblank_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_divide_q <= 3'd4;
			irq_reload_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLOCK_DIVIDE: clock_divide_q <= cfg_data[2:0];
				CFG_IRQ_RELOAD:   irq_reload_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vblank_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				vblank_q <= vblank_next;
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload holds until the next accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.dot_step       <= dot.step;
			out_q.dot_x          <= dot.x;
			out_q.scanline       <= dot.y;
			out_q.scroll_address <= scroll_next;
			out_q.fetch_valid    <= fetch_valid;
			out_q.fetch_address  <= fetch_valid ? {NT_BASE[13:12], scroll_next[11:0]} : NT_BASE;
			out_q.vblank_flag    <= vblank_next;
			out_q.nmi_pulse      <= vblank_set && in_data.nmi_enable;
			out_q.irq_pulse      <= irq_pulse;
		end
	end

	`include "video_dot_timing_scroll_unit_assert.svh"

	`VDTS_ASSERT_NXT(a_accept_fills, accept, out_valid_q)
	`VDTS_ASSERT_IMP(a_nmi_in_vblank, out_valid_q && out_q.nmi_pulse, out_q.vblank_flag)
	`VDTS_ASSERT_IMP(a_fetch_base, out_valid_q && !out_q.fetch_valid, out_q.fetch_address == NT_BASE)
	`VDTS_ASSERT_IMP(a_irq_at_dot, out_valid_q && out_q.irq_pulse,
		out_q.dot_step && out_q.dot_x == IRQ_DOT)

endmodule

// ===== verif/dot_scroll_checker.sv =====
// ----------------------------------------------------------------------------
// dot_scroll_checker
// Watches the configuration port and both item channels of the dot timing and
// scroll unit. It keeps its own copy of the divider, dot and line counters,
// scroll address, scanline IRQ counter and vblank bit, predicts the result of
// every accepted input item and compares each accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dot_scroll_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  vdts_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  vdts_pkg::out_item_t out_data,
	output int unsigned         mismatch_count,
	output int unsigned         open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import vdts_pkg::*;

	localparam logic [8:0]  DOTS_PER_LINE   = 9'd341;
	localparam logic [8:0]  LINES_PER_FRAME = 9'd262;
	localparam logic [8:0]  HCOPY_DOT       = 9'd256;
	localparam logic [8:0]  VCOPY_FIRST_DOT = 9'd279;
	localparam logic [8:0]  VCOPY_END_DOT   = 9'd304;
	localparam logic [14:0] VCOPY_MASK      = 15'h7BE0;
	localparam logic [14:0] HCOPY_MASK      = 15'h041F;
	localparam logic [4:0]  COARSE_X_LAST   = 5'd31;
	localparam logic [4:0]  COARSE_Y_ROW29  = 5'd29;
	localparam logic [4:0]  COARSE_Y_LAST   = 5'd31;
	localparam logic [2:0]  FINE_Y_LAST     = 3'd7;

	logic [2:0]  div_setting;
	logic [7:0]  irq_reload_setting;
	logic [2:0]  div_count;
	logic [8:0]  dot_pos;
	logic [8:0]  line_pos;
	logic [14:0] scroll_addr;
	logic [7:0]  irq_count;
	logic        irq_reload_due;
	logic        vblank;

	out_item_t timing_results_due[$];

	// advance the timing state by one item and return the result it produces
	function automatic out_item_t advance_video_timing(input in_item_t it);
		out_item_t  r;
		logic [2:0] nxt;
		logic [8:0] x;
		logic [8:0] y;
		logic       step;
		logic       fetch;
		logic       nmi;
		logic       irq;
		x     = dot_pos;
		y     = line_pos;
		step  = 1'b0;
		fetch = 1'b0;
		nmi   = 1'b0;
		irq   = 1'b0;
		case (it.req_type)
			REQ_LOAD:   scroll_addr = it.new_address;
			REQ_STATUS: vblank = 1'b0;
			REQ_RELOAD: irq_reload_due = 1'b1;
			default: begin
				nxt = div_count + 3'd1;
				if (nxt >= div_setting) begin
					div_count = 3'd0;
					step      = 1'b1;
				end else begin
					div_count = nxt;
				end
			end
		endcase
		if (step) begin
			if (it.rendering_on) begin
				if (x == IRQ_DOT && y <= LAST_VISIBLE_LINE) begin
					if (irq_count == 8'd0 || irq_reload_due) begin
						irq_count      = irq_reload_setting;
						irq_reload_due = 1'b0;
					end else begin
						irq_count = irq_count - 8'd1;
					end
					irq = !it.cpu_irq_masked && it.irq_enabled && irq_count == 8'd0;
				end
				if (y == PRERENDER_LINE && x >= VCOPY_FIRST_DOT && x < VCOPY_END_DOT)
					scroll_addr = (scroll_addr & ~VCOPY_MASK) | (it.temp_address & VCOPY_MASK);
				if (y <= LAST_VISIBLE_LINE || y == PRERENDER_LINE) begin
					if (x < HCOPY_DOT && (x[2:0] + it.fine_x) == 3'd7) begin
						// coarse X, wrapping into the neighbor nametable
						if (scroll_addr[4:0] == COARSE_X_LAST)
							scroll_addr = {scroll_addr[14:11], ~scroll_addr[10],
								scroll_addr[9:5], 5'd0};
						else
							scroll_addr = scroll_addr + 15'd1;
						fetch = 1'b1;
					end
					if (x == IRQ_DOT) begin
						if (scroll_addr[14:12] != FINE_Y_LAST) begin
							scroll_addr[14:12] = scroll_addr[14:12] + 3'd1;
						end else begin
							scroll_addr[14:12] = 3'd0;
							if (scroll_addr[9:5] == COARSE_Y_ROW29) begin
								scroll_addr[11]  = ~scroll_addr[11];
								scroll_addr[9:5] = 5'd0;
							end else if (scroll_addr[9:5] == COARSE_Y_LAST) begin
								scroll_addr[9:5] = 5'd0;
							end else begin
								scroll_addr[9:5] = scroll_addr[9:5] + 5'd1;
							end
						end
					end
					if (x == HCOPY_DOT) begin
						scroll_addr = (scroll_addr & ~HCOPY_MASK) | (it.temp_address & HCOPY_MASK);
						fetch       = 1'b1;
					end
				end
			end
			if (y == VBLANK_LINE && x == 9'd1) begin
				vblank = 1'b1;
				nmi    = it.nmi_enable;
			end
			dot_pos = x + 9'd1;
			if (dot_pos >= DOTS_PER_LINE) begin
				dot_pos  = 9'd0;
				line_pos = y + 9'd1;
				if (line_pos >= LINES_PER_FRAME)
					line_pos = 9'd0;
			end
		end
		r.dot_step       = step;
		r.dot_x          = x;
		r.scanline       = y;
		r.scroll_address = scroll_addr;
		r.fetch_valid    = fetch;
		r.fetch_address  = fetch ? (NT_BASE | {2'b00, scroll_addr[11:0]}) : NT_BASE;
		r.vblank_flag    = vblank;
		r.nmi_pulse      = nmi;
		r.irq_pulse      = irq;
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			div_setting        = 3'd4;
			irq_reload_setting = 8'd0;
			div_count          = 3'd0;
			dot_pos            = 9'd0;
			line_pos           = 9'd0;
			scroll_addr        = 15'd0;
			irq_count          = 8'd0;
			irq_reload_due     = 1'b0;
			vblank             = 1'b0;
			timing_results_due.delete();
			mismatch_count     = 0;
			open_count         = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLOCK_DIVIDE: div_setting = cfg_data[2:0];
					CFG_IRQ_RELOAD:   irq_reload_setting = cfg_data;
				endcase
			end
			if (in_valid && in_ready)
				timing_results_due.push_back(advance_video_timing(in_data));
			if (out_valid && out_ready) begin
				if (timing_results_due.size() == 0) begin
					$display("%0t: result with none expected, expected nothing, actual 0x%0h",
						$time, out_data);
					mismatch_count++;
				end else begin
					want = timing_results_due.pop_front();
					check_field("dot_step", want.dot_step, out_data.dot_step);
					check_field("dot_x", want.dot_x, out_data.dot_x);
					check_field("scanline", want.scanline, out_data.scanline);
					check_field("scroll_address", want.scroll_address, out_data.scroll_address);
					check_field("fetch_valid", want.fetch_valid, out_data.fetch_valid);
					check_field("fetch_address", want.fetch_address, out_data.fetch_address);
					check_field("vblank_flag", want.vblank_flag, out_data.vblank_flag);
					check_field("nmi_pulse", want.nmi_pulse, out_data.nmi_pulse);
					check_field("irq_pulse", want.irq_pulse, out_data.irq_pulse);
				end
			end
			open_count = timing_results_due.size();
		end
	end

endmodule

// ===== verif/tb_video_dot_timing_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// tb_video_dot_timing_scroll_unit
// Drives the dot timing and scroll unit with a short directed sequence, eight
// random phases over all divider settings, and a tick-heavy sweep through the
// first scanlines. Both channels idle at random; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_video_dot_timing_scroll_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import vdts_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 4_000_000;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS      = 100;
	localparam int unsigned SWEEP_BLOCKS     = 6;
	localparam int unsigned BLOCK_ITEMS      = 100;

	localparam logic [7:0] DIVIDE_SEQ [8] = '{8'd5, 8'd0, 8'd7, 8'd2, 8'd4, 8'd1, 8'd6, 8'd3};
	localparam logic [7:0] RELOAD_SEQ [8] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd5, 8'd128, 8'd3};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	int unsigned mismatch_count;
	int unsigned open_count;
	int unsigned cycle_count;
	bit          idle_off;

	video_dot_timing_scroll_unit u_dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data
	);

	dot_scroll_checker u_checker (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.mismatch_count,
		.open_count
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [1:0] req, input logic [14:0] addr,
			input logic [14:0] temp, input logic [2:0] fx, input logic [3:0] flags);
		in_item_t it;
		it.req_type       = req;
		it.new_address    = addr;
		it.temp_address   = temp;
		it.fine_x         = fx;
		it.rendering_on   = flags[3];
		it.nmi_enable     = flags[2];
		it.irq_enabled    = flags[1];
		it.cpu_irq_masked = flags[0];
		return it;
	endfunction

	function automatic in_item_t rand_item(input int unsigned tick_pct);
		in_item_t it;
		if ($urandom_range(0, 99) < tick_pct) begin
			it.req_type = REQ_TICK;
		end else begin
			case ($urandom_range(0, 2))
				0:       it.req_type = REQ_LOAD;
				1:       it.req_type = REQ_STATUS;
				default: it.req_type = REQ_RELOAD;
			endcase
		end
		it.new_address = 15'($urandom);
		// bias loads toward the last fine row of the coarse-Y wrap rows
		if ($urandom_range(0, 3) == 0) begin
			it.new_address[14:12] = 3'd7;
			it.new_address[9:5]   = 5'($urandom_range(29, 31));
		end
		it.temp_address   = 15'($urandom);
		it.fine_x         = 3'($urandom);
		it.rendering_on   = $urandom_range(0, 9) != 0;
		it.nmi_enable     = $urandom_range(0, 3) != 0;
		it.irq_enabled    = 1'($urandom);
		it.cpu_irq_masked = $urandom_range(0, 3) == 0;
		return it;
	endfunction

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_item(input in_item_t it);
		int unsigned gap;
		gap = idle_off ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_results_done();
		while (open_count != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// result side: random stalls, plus two long hold-offs while items keep coming
	initial begin
		int unsigned gap;
		int unsigned taken;
		taken     = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == 100 || taken == 700)
				gap = LONG_HOLD_CYCLES;
			else
				gap = idle_off ? 0 : $urandom_range(0, 3);
			@(negedge clk);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		idle_off  = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_CLOCK_DIVIDE;
		cfg_data  = 8'd0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_CLOCK_DIVIDE, 8'd1);
		write_reg(CFG_IRQ_RELOAD, 8'd0);

		// directed: address extremes, coarse-X wrap, every request kind
		send_item(make_item(REQ_LOAD, 15'h7FFF, 15'h0000, 3'd7, 4'hF));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h0000, 3'd7, 4'b1000));
		send_item(make_item(REQ_STATUS, 15'h7FFF, 15'h7FFF, 3'd0, 4'h0));
		send_item(make_item(REQ_RELOAD, 15'h0000, 15'h7FFF, 3'd7, 4'hF));
		send_item(make_item(REQ_LOAD, 15'h0000, 15'h7FFF, 3'd0, 4'h0));
		send_item(make_item(REQ_TICK, 15'h7FFF, 15'h7FFF, 3'd0, 4'hF));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h7FFF, 3'd5, 4'b1010));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h0000, 3'd4, 4'b0101));
		send_item(make_item(REQ_LOAD, 15'h001F, 15'h5555, 3'd3, 4'b1000));
		send_item(make_item(REQ_TICK, 15'h2AAA, 15'h5555, 3'd3, 4'b1000));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h2AAA, 3'd2, 4'b1111));
		send_item(make_item(REQ_STATUS, 15'h0000, 15'h0000, 3'd1, 4'b1000));
		send_item(make_item(REQ_RELOAD, 15'h7FFF, 15'h0000, 3'd0, 4'b1000));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h7FFF, 3'd0, 4'b0000));
		send_item(make_item(REQ_LOAD, 15'h7BFF, 15'h041F, 3'd6, 4'b1110));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h7BE0, 3'd6, 4'b1110));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h7BE0, 3'd7, 4'b1001));
		send_item(make_item(REQ_TICK, 15'h0000, 15'h0000, 3'd7, 4'b1000));
		stop_sending();
		wait_results_done();

		// random phases over every divider setting; one runs without idling
		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_CLOCK_DIVIDE, DIVIDE_SEQ[p]);
			write_reg(CFG_IRQ_RELOAD, RELOAD_SEQ[p]);
			idle_off = (p == 3);
			repeat (PHASE_ITEMS) send_item(rand_item(70));
			stop_sending();
			wait_results_done();
		end

		// tick-heavy sweep through the first lines: fine-Y, horizontal copy, IRQ dot
		write_reg(CFG_CLOCK_DIVIDE, 8'd1);
		write_reg(CFG_IRQ_RELOAD, 8'd3);
		for (int blk = 0; blk < SWEEP_BLOCKS; blk++) begin
			if (blk == SWEEP_BLOCKS / 2) begin
				stop_sending();
				wait_results_done();
				write_reg(CFG_CLOCK_DIVIDE, 8'd0);
				write_reg(CFG_IRQ_RELOAD, 8'd1);
			end
			idle_off = (blk % 4 == 0);
			repeat (BLOCK_ITEMS) send_item(rand_item(94));
		end
		stop_sending();
		idle_off = 1'b0;
		wait_results_done();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && open_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
